[rtl/brmr_pkg.sv]
// ----------------------------------------------------------------------------
// brmr_pkg
// Shared types and constants of the broadcast ring with several readers:
// payload structs, opcodes and the controller command bundle.
// ----------------------------------------------------------------------------
package brmr_pkg;

    localparam int BRMR_RING_BYTES   = 4096;
    localparam int BRMR_CLIENT_COUNT = 4;
    localparam int BRMR_AVAIL_W      = 13;

    localparam logic [2:0] OP_WRITE      = 3'd0;
    localparam logic [2:0] OP_READ       = 3'd1;
    localparam logic [2:0] OP_ACTIVATE   = 3'd2;
    localparam logic [2:0] OP_DEACTIVATE = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] client;
        logic [7:0] write_byte;
        logic       last_of_message;
    } brmr_in_t;

    typedef struct packed {
        logic [7:0]              read_byte;
        logic                    read_valid;
        logic [15:0]             dropped_total;
        logic                    client_is_active;
        logic [BRMR_AVAIL_W-1:0] bytes_available;
    } brmr_out_t;

    typedef struct packed {
        logic load;
        logic commit;
    } brmr_cmd_t;

endpackage

[rtl/brmr_ctrl.sv]
// ----------------------------------------------------------------------------
// brmr_ctrl
// Item sequencer: takes one item, waits for the ring read, then commits the
// state update and the result into the output register.
// ----------------------------------------------------------------------------
module brmr_ctrl
    import brmr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output brmr_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold here while the previous result is still unclaimed
                cmd.commit = !m_valid_reg || m_ready;
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = cmd.commit || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[rtl/brmr_datapath.sv]
// ----------------------------------------------------------------------------
// brmr_datapath
// Ring memory, write and read positions, active flags, loss accumulator and
// the output register.
// ----------------------------------------------------------------------------
module brmr_datapath
    import brmr_pkg::*;
#(
    parameter int RING_BYTES   = BRMR_RING_BYTES,
    parameter int CLIENT_COUNT = BRMR_CLIENT_COUNT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  brmr_cmd_t cmd,
    input  brmr_in_t  s_data,
    output brmr_out_t m_data
);

    localparam int POS_MOD = 2 * RING_BYTES;
    localparam int POS_W   = $clog2(POS_MOD);
    localparam int IDX_W   = $clog2(RING_BYTES);
    localparam int CNT_W   = $clog2(CLIENT_COUNT + 1);

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [POS_W:0]   pos_ext_t;
    typedef logic [IDX_W-1:0] idx_t;

    function automatic pos_t pos_inc(input pos_t p);
        return (p == pos_t'(POS_MOD - 1)) ? '0 : p + pos_t'(1);
    endfunction

    // a - b modulo the sequence range
    function automatic pos_t pos_diff(input pos_t a, input pos_t b);
        pos_ext_t s;
        s = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            s = s + pos_ext_t'(POS_MOD);
        end
        return pos_t'(s);
    endfunction

    // oldest position still held after the next write
    function automatic pos_t pos_skip(input pos_t wp);
        pos_ext_t s;
        s = {1'b0, wp} + pos_ext_t'(RING_BYTES + 1);
        if (s >= pos_ext_t'(POS_MOD)) begin
            s = s - pos_ext_t'(POS_MOD);
        end
        return pos_t'(s);
    endfunction

    function automatic idx_t pos_idx(input pos_t p);
        return (p >= pos_t'(RING_BYTES)) ? idx_t'(p - pos_t'(RING_BYTES)) : idx_t'(p);
    endfunction

    logic [7:0]              ring_mem [RING_BYTES];
    logic [7:0]              rd_data_reg;
    brmr_in_t                item_reg;
    brmr_out_t               out_reg;
    brmr_out_t               res;

    pos_t                    wp_reg;
    pos_t                    wp_next;
    pos_t                    rp_reg  [CLIENT_COUNT];
    pos_t                    rp_next [CLIENT_COUNT];
    logic [CLIENT_COUNT-1:0] act_reg;
    logic [CLIENT_COUNT-1:0] act_next;
    logic [15:0]             acc_reg;
    logic [15:0]             acc_next;

    logic [CLIENT_COUNT-1:0] ld_hit;
    logic [CLIENT_COUNT-1:0] ex_hit;
    logic [CLIENT_COUNT-1:0] over;
    pos_t                    ld_rp;
    pos_t                    sel_rp;
    logic                    sel_act;
    pos_t                    post_rp;
    logic                    post_act;
    pos_t                    skip_pos;
    logic [CNT_W-1:0]        drop_cnt;
    logic [16:0]             acc_sum;
    logic [15:0]             acc_sat;
    logic                    mem_wr;

    // client selection, out of range clients match nothing
    always_comb begin
        ld_rp   = '0;
        sel_rp  = '0;
        sel_act = 1'b0;
        for (int i = 0; i < CLIENT_COUNT; i++) begin
            ld_hit[i] = (32'(s_data.client) == i);
            ex_hit[i] = (32'(item_reg.client) == i);
            if (ld_hit[i]) begin
                ld_rp = rp_reg[i];
            end
            if (ex_hit[i]) begin
                sel_rp  = rp_reg[i];
                sel_act = act_reg[i];
            end
        end
    end

    // an active client never lags more than one ring, so an overrun loses one byte
    always_comb begin
        for (int i = 0; i < CLIENT_COUNT; i++) begin
            over[i] = act_reg[i] && (pos_diff(wp_reg, rp_reg[i]) >= pos_t'(RING_BYTES));
        end
        skip_pos = pos_skip(wp_reg);
        drop_cnt = CNT_W'($countones(over));
        acc_sum  = {1'b0, acc_reg} + 17'(drop_cnt);
        acc_sat  = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
    end

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        act_next = act_reg;
        acc_next = acc_reg;
        mem_wr   = 1'b0;
        res      = '0;
        if (cmd.commit) begin
            unique case (item_reg.opcode) inside
                OP_WRITE: begin
                    for (int i = 0; i < CLIENT_COUNT; i++) begin
                        if (over[i]) begin
                            rp_next[i] = skip_pos;
                        end
                    end
                    mem_wr  = 1'b1;
                    wp_next = pos_inc(wp_reg);
                    if (item_reg.last_of_message) begin
                        res.dropped_total = acc_sat;
                        acc_next          = '0;
                    end else begin
                        acc_next = acc_sat;
                    end
                end
                OP_READ: begin
                    if (sel_act && (sel_rp != wp_reg)) begin
                        res.read_byte  = rd_data_reg;
                        res.read_valid = 1'b1;
                        for (int i = 0; i < CLIENT_COUNT; i++) begin
                            if (ex_hit[i]) begin
                                rp_next[i] = pos_inc(rp_reg[i]);
                            end
                        end
                    end
                end
                OP_ACTIVATE, OP_DEACTIVATE: begin
                    for (int i = 0; i < CLIENT_COUNT; i++) begin
                        if (ex_hit[i]) begin
                            rp_next[i]  = wp_reg;
                            act_next[i] = (item_reg.opcode == OP_ACTIVATE);
                        end
                    end
                end
                OP_CLEAR: begin
                    wp_next  = '0;
                    acc_next = '0;
                    for (int i = 0; i < CLIENT_COUNT; i++) begin
                        rp_next[i] = '0;
                    end
                end
                default: ;
            endcase
        end

        // status of the addressed client after the update
        post_rp  = '0;
        post_act = 1'b0;
        for (int i = 0; i < CLIENT_COUNT; i++) begin
            if (ex_hit[i]) begin
                post_rp  = rp_next[i];
                post_act = act_next[i];
            end
        end
        res.client_is_active = post_act;
        res.bytes_available  = post_act ? BRMR_AVAIL_W'(pos_diff(wp_next, post_rp)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            ring_mem[pos_idx(wp_reg)] <= item_reg.write_byte;
        end
        if (cmd.load) begin
            rd_data_reg <= ring_mem[pos_idx(ld_rp)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.commit) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '{default: '0};
            act_reg <= '0;
            acc_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            act_reg <= act_next;
            acc_reg <= acc_next;
        end
    end

    assign m_data = out_reg;

endmodule

[rtl/broadcast_ring_multi_reader.sv]
// ----------------------------------------------------------------------------
// broadcast_ring_multi_reader
// One writer broadcasts bytes into a ring read independently by several
// clients, with overrun loss counting per message.
// ----------------------------------------------------------------------------
// An item is handled in an accept state and then an update state. On accept the
// addressed client's byte is read from the ring memory, whose read data is
// registered; on update positions, flags and the loss count change and the
// result register is loaded. A new item is taken while the previous result
// still waits on the result channel; the block holds in its update state only
// while that result is not yet transferred. No clearing pass runs after reset:
// an entry is read only after it has been written.
module broadcast_ring_multi_reader
    import brmr_pkg::*;
#(
    parameter int RING_BYTES   = BRMR_RING_BYTES,
    parameter int CLIENT_COUNT = BRMR_CLIENT_COUNT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  brmr_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output brmr_out_t m_data
);

    brmr_cmd_t cmd;

    brmr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    brmr_datapath #(
        .RING_BYTES   (RING_BYTES),
        .CLIENT_COUNT (CLIENT_COUNT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

`ifndef SYNTH
    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    a_read_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_valid |-> m_data.client_is_active)
        else $error("byte delivered to an inactive client");

    a_drop_only_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.dropped_total != 16'd0) |-> !m_data.read_valid)
        else $error("loss report on a read result");

    a_inactive_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.client_is_active |-> (m_data.bytes_available == '0))
        else $error("inactive client reports unread bytes");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the broadcast ring with several readers. A local
// model of the ring, the write and read positions, the active flags and the
// loss count predicts each result as items are accepted. The bench covers
// directed corner cases, a long output stall, and random traffic with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import brmr_pkg::*;

    localparam int SEQ_W       = $clog2(2 * BRMR_RING_BYTES);
    localparam int LOSS_MAX    = 65535;
    localparam int CYCLE_LIMIT = 2_000_000;

    // opcodes the block leaves unused
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    brmr_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    brmr_out_t m_data;

    brmr_out_t   expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    int unsigned sink_hold_req = 0;

    // local copy of the ring state
    logic [7:0]       ring_mem [BRMR_RING_BYTES];
    logic [SEQ_W-1:0] wr_seq = '0;
    logic [SEQ_W-1:0] rd_seq [BRMR_CLIENT_COUNT];
    bit               client_on [BRMR_CLIENT_COUNT];
    int unsigned      loss_sum = 0;

    broadcast_ring_multi_reader i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic brmr_in_t make_item(input logic [2:0] op, input logic [1:0] client,
                                           input logic [7:0] wbyte, input logic last);
        brmr_in_t it;
        it.opcode          = op;
        it.client          = client;
        it.write_byte      = wbyte;
        it.last_of_message = last;
        return it;
    endfunction

    // advances the local ring state by one item and returns its result
    function automatic brmr_out_t ring_predict(input brmr_in_t it);
        brmr_out_t        r;
        logic [SEQ_W-1:0] lag;
        int               c;
        int               i;
        bit               c_ok;
        r    = '0;
        c    = it.client;
        c_ok = (c < BRMR_CLIENT_COUNT);
        case (it.opcode)
            OP_WRITE: begin
                // a client a full ring behind loses the byte about to be overwritten
                for (i = 0; i < BRMR_CLIENT_COUNT; i++) begin
                    if (client_on[i]) begin
                        lag = wr_seq - rd_seq[i];
                        if (lag >= BRMR_RING_BYTES) begin
                            loss_sum = loss_sum + lag + 1 - BRMR_RING_BYTES;
                            if (loss_sum > LOSS_MAX) begin
                                loss_sum = LOSS_MAX;
                            end
                            rd_seq[i] = SEQ_W'(wr_seq + 1 - BRMR_RING_BYTES);
                        end
                    end
                end
                ring_mem[wr_seq[SEQ_W-2:0]] = it.write_byte;
                wr_seq = wr_seq + SEQ_W'(1);
                if (it.last_of_message) begin
                    r.dropped_total = loss_sum[15:0];
                    loss_sum = 0;
                end
            end
            OP_READ: begin
                if (c_ok && client_on[c] && wr_seq != rd_seq[c]) begin
                    r.read_byte  = ring_mem[rd_seq[c][SEQ_W-2:0]];
                    r.read_valid = 1'b1;
                    rd_seq[c]    = rd_seq[c] + SEQ_W'(1);
                end
            end
            OP_ACTIVATE, OP_DEACTIVATE: begin
                if (c_ok) begin
                    rd_seq[c]    = wr_seq;
                    client_on[c] = (it.opcode == OP_ACTIVATE);
                end
            end
            OP_CLEAR: begin
                wr_seq = '0;
                for (i = 0; i < BRMR_CLIENT_COUNT; i++) begin
                    rd_seq[i] = '0;
                end
                loss_sum = 0;
            end
            default: begin
            end
        endcase
        if (c_ok && client_on[c]) begin
            r.client_is_active = 1'b1;
            r.bytes_available  = wr_seq - rd_seq[c];
        end
        return r;
    endfunction

    task automatic send_item(input brmr_in_t it);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(ring_predict(it));
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // result side: random stalls per transfer, long hold-off on request
    initial begin : result_sink
        brmr_out_t   want;
        int unsigned pause;
        pause = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: byte=%0d valid=%0d drop=%0d act=%0d avail=%0d",
                                 m_data.read_byte, m_data.read_valid, m_data.dropped_total,
                                 m_data.client_is_active, m_data.bytes_available);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.read_byte !== want.read_byte ||
                        m_data.read_valid !== want.read_valid ||
                        m_data.dropped_total !== want.dropped_total ||
                        m_data.client_is_active !== want.client_is_active ||
                        m_data.bytes_available !== want.bytes_available) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"mismatch: expected byte=%0d valid=%0d drop=%0d act=%0d ",
                                      "avail=%0d, got byte=%0d valid=%0d drop=%0d act=%0d ",
                                      "avail=%0d"},
                                     want.read_byte, want.read_valid, want.dropped_total,
                                     want.client_is_active, want.bytes_available,
                                     m_data.read_byte, m_data.read_valid, m_data.dropped_total,
                                     m_data.client_is_active, m_data.bytes_available);
                        end
                    end
                end
                pause = sink_idle_on ? $urandom_range(0, 12) : 0;
            end
            if (sink_hold_req != 0) begin
                pause = sink_hold_req;
                sink_hold_req = 0;
            end
            if (pause != 0) begin
                m_ready <= 1'b0;
                pause--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed_ops;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        // inactive and empty reads, unused opcodes
        send_item(make_item(OP_READ, 2'd0, 8'h00, 1'b0));
        send_item(make_item(OP_RSVD5, 2'd1, 8'h00, 1'b0));
        send_item(make_item(OP_RSVD6, 2'd2, 8'hFF, 1'b0));
        send_item(make_item(OP_RSVD7, 2'd3, 8'hFF, 1'b1));
        send_item(make_item(OP_ACTIVATE, 2'd0, 8'h00, 1'b0));
        send_item(make_item(OP_READ, 2'd0, 8'h00, 1'b1));
        send_item(make_item(OP_WRITE, 2'd0, 8'h00, 1'b0));
        send_item(make_item(OP_WRITE, 2'd0, 8'hFF, 1'b1));
        send_item(make_item(OP_ACTIVATE, 2'd3, 8'h00, 1'b0));
        send_item(make_item(OP_WRITE, 2'd3, 8'hA5, 1'b0));
        send_item(make_item(OP_READ, 2'd0, 8'h00, 1'b0));
        send_item(make_item(OP_READ, 2'd0, 8'h00, 1'b0));
        send_item(make_item(OP_READ, 2'd0, 8'h00, 1'b0));
        send_item(make_item(OP_READ, 2'd0, 8'h00, 1'b0));
        send_item(make_item(OP_READ, 2'd3, 8'h00, 1'b0));
        send_item(make_item(OP_DEACTIVATE, 2'd0, 8'h00, 1'b0));
        send_item(make_item(OP_READ, 2'd0, 8'h00, 1'b0));
        send_item(make_item(OP_WRITE, 2'd0, 8'h5A, 1'b1));
        // clear keeps client 3 active but rewinds it
        send_item(make_item(OP_CLEAR, 2'd3, 8'h00, 1'b0));
        send_item(make_item(OP_WRITE, 2'd3, 8'h3C, 1'b1));
        send_item(make_item(OP_READ, 2'd3, 8'h00, 1'b0));
        send_item(make_item(OP_ACTIVATE, 2'd1, 8'h00, 1'b0));
        send_item(make_item(OP_ACTIVATE, 2'd2, 8'h00, 1'b1));
        send_item(make_item(OP_DEACTIVATE, 2'd3, 8'h00, 1'b0));
        send_item(make_item(OP_READ, 2'd2, 8'h00, 1'b1));
        wait_drained();
    endtask

    task automatic test_output_backpressure;
        int n;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        send_item(make_item(OP_ACTIVATE, 2'd1, 8'h00, 1'b0));
        // result side stalls long enough for the block to back up its input
        sink_hold_req = 300;
        for (n = 0; n < 48; n++) begin
            send_item(make_item((n % 3 == 2) ? OP_READ : OP_WRITE, 2'd1, 8'($urandom),
                                (n % 8 == 7)));
        end
        wait_drained();
    endtask

    task automatic test_random_traffic;
        int          n;
        int          k;
        int unsigned roll;
        logic [2:0]  op;
        logic        last;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (k = 0; k < BRMR_CLIENT_COUNT; k++) begin
            send_item(make_item(OP_ACTIVATE, 2'(k), 8'($urandom), 1'($urandom)));
        end
        for (n = 0; n < 1300; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                op = OP_WRITE;
            end else if (roll < 78) begin
                op = OP_READ;
            end else if (roll < 86) begin
                op = OP_ACTIVATE;
            end else if (roll < 91) begin
                op = OP_DEACTIVATE;
            end else if (roll < 93) begin
                op = OP_CLEAR;
            end else begin
                op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
            end
            last = (op == OP_WRITE) ? ($urandom_range(0, 3) == 0) : 1'($urandom);
            if ($urandom_range(0, 149) == 0) begin
                src_idle_on = !src_idle_on;
            end
            if ($urandom_range(0, 149) == 0) begin
                sink_idle_on = !sink_idle_on;
            end
            // sender pauses once until everything outstanding is back
            if (n == 650) begin
                wait_drained();
            end
            send_item(make_item(op, 2'($urandom_range(0, 3)), 8'($urandom), last));
        end
        wait_drained();
    endtask

    initial begin
        int k;
        for (k = 0; k < BRMR_CLIENT_COUNT; k++) begin
            rd_seq[k]    = '0;
            client_on[k] = 1'b0;
        end
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_output_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (16) @(posedge aclk);
        mismatch_count += expected_results.size();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
rtl/brmr_pkg.sv
rtl/brmr_ctrl.sv
rtl/brmr_datapath.sv
rtl/broadcast_ring_multi_reader.sv
sim/testbench.sv
